[rtl/core/hmssw_pkg.sv]
// shared types, codes and time arithmetic for the hms stopwatch
`timescale 1ns / 1ps

package hmssw_pkg;

   // operation codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_TOGGLE = 2'd1;
   localparam logic [1:0] OP_RESET  = 2'd2;

   // digit limits
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [5:0] SECOND_MAX = 6'd59;
   localparam logic [9:0] MILLI_MAX  = 10'd999;

   // register byte addresses
   localparam logic [1:0] CSR_ADDR_ROUND = 2'd0;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] milli;
   } time_type;

   typedef struct packed {
      logic [1:0] op;
      time_type   now;
   } item_type;

   // a - b over hour:minute:second:milli, hours modulo 24
   function automatic time_type time_sub(time_type a, time_type b);
      time_type   r;
      logic [10:0] tm;
      logic [6:0]  ts;
      logic [6:0]  tn;
      logic [5:0]  th;
      logic        bm;
      logic        bs;
      logic        bn;
      bm = (a.milli < b.milli);
      tm = {1'b0, a.milli} - {1'b0, b.milli};
      if (bm) tm = tm + 11'd1000;
      bs = ({1'b0, a.second} < ({1'b0, b.second} + {6'd0, bm}));
      ts = {1'b0, a.second} - {1'b0, b.second} - {6'd0, bm};
      if (bs) ts = ts + 7'd60;
      bn = ({1'b0, a.minute} < ({1'b0, b.minute} + {6'd0, bs}));
      tn = {1'b0, a.minute} - {1'b0, b.minute} - {6'd0, bs};
      if (bn) tn = tn + 7'd60;
      th = {1'b0, a.hour} - {1'b0, b.hour} - {5'd0, bn};
      if ({1'b0, a.hour} < ({1'b0, b.hour} + {5'd0, bn})) th = th + 6'd24;
      r.milli  = tm[9:0];
      r.second = ts[5:0];
      r.minute = tn[5:0];
      r.hour   = th[4:0];
      return r;
   endfunction

   // a + b over hour:minute:second:milli, carry out of hours dropped
   function automatic time_type time_add(time_type a, time_type b);
      time_type   r;
      logic [10:0] sm;
      logic [6:0]  ss;
      logic [6:0]  sn;
      logic [5:0]  sh;
      logic        cm;
      logic        cs;
      logic        cn;
      sm = {1'b0, a.milli} + {1'b0, b.milli};
      cm = (sm >= 11'd1000);
      if (cm) sm = sm - 11'd1000;
      ss = {1'b0, a.second} + {1'b0, b.second} + {6'd0, cm};
      cs = (ss >= 7'd60);
      if (cs) ss = ss - 7'd60;
      sn = {1'b0, a.minute} + {1'b0, b.minute} + {6'd0, cs};
      cn = (sn >= 7'd60);
      if (cn) sn = sn - 7'd60;
      sh = {1'b0, a.hour} + {1'b0, b.hour} + {5'd0, cn};
      if (sh >= 6'd24) sh = sh - 6'd24;
      r.milli  = sm[9:0];
      r.second = ss[5:0];
      r.minute = sn[5:0];
      r.hour   = sh[4:0];
      return r;
   endfunction

endpackage

[rtl/core/hmssw_csr.sv]
// configuration register block with apb-style access
`timescale 1ns / 1ps

module hmssw_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        round_up_enable
);
   import hmssw_pkg::*;

   logic round_ff;
   logic round_in;

   assign pready = 1'b1;

   // the only register sits in word zero; the address is ignored on write
   always_comb begin
      round_in = round_ff;
      if (psel && penable && pwrite) round_in = pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= 1'b0;
      end else begin
         round_ff <= round_in;
      end
   end

   // read mux
   always_comb begin
      prdata = 32'd0;
      if (paddr == CSR_ADDR_ROUND) prdata = {31'd0, round_ff};
   end

   assign round_up_enable = round_ff;

endmodule

[rtl/core/hmssw_in_stage.sv]
// input register with range clamping of the time-of-day fields
`timescale 1ns / 1ps

module hmssw_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [4:0]           req_now_hour,
   input  logic [5:0]           req_now_minute,
   input  logic [5:0]           req_now_second,
   input  logic [9:0]           req_now_milli,
   input  logic                 take,
   output logic                 item_valid,
   output hmssw_pkg::item_type  item
);
   import hmssw_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;

   assign req_ready = !valid_ff || take;

   // clamp each field to its digit maximum
   always_comb begin
      item_in            = item_ff;
      valid_in           = take ? 1'b0 : valid_ff;
      if (req_valid && req_ready) begin
         valid_in          = 1'b1;
         item_in.op        = req_op;
         item_in.now.hour   = (req_now_hour   > HOUR_MAX)   ? HOUR_MAX   : req_now_hour;
         item_in.now.minute = (req_now_minute > MINUTE_MAX) ? MINUTE_MAX : req_now_minute;
         item_in.now.second = (req_now_second > SECOND_MAX) ? SECOND_MAX : req_now_second;
         item_in.now.milli  = (req_now_milli  > MILLI_MAX)  ? MILLI_MAX  : req_now_milli;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/core/hmssw_core.sv]
// stopwatch state update; the state registers double as the result register
`timescale 1ns / 1ps

module hmssw_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 round_up_enable,
   input  logic                 item_valid,
   input  hmssw_pkg::item_type  item,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hmssw_pkg::time_type  run_time,
   output hmssw_pkg::time_type  seg_time,
   output logic                 is_running
);
   import hmssw_pkg::*;

   logic     run_ff;
   logic     run_in;
   time_type ref_ff;
   time_type ref_in;
   time_type base_ff;
   time_type base_in;
   time_type cur_ff;
   time_type cur_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;

   time_type elapsed;
   time_type running;
   time_type seg_raw;
   time_type seg_round;
   logic [6:0] sec_up;
   logic [6:0] min_up;
   logic [5:0] hour_up;

   // an item moves on when the result slot is free or being emptied
   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   // elapsed and running value for a tick
   assign elapsed = time_sub(item.now, ref_ff);
   assign running = time_add(elapsed, base_ff);

   // segment time with optional round-up to whole minutes
   assign seg_raw = time_sub(cur_ff, base_ff);
   always_comb begin
      sec_up  = {1'b0, seg_raw.second} + {6'd0, (seg_raw.milli != 10'd0)};
      min_up  = {1'b0, seg_raw.minute} + {6'd0, (sec_up != 7'd0)};
      hour_up = {1'b0, seg_raw.hour};
      if (min_up >= 7'd60) begin
         min_up  = min_up - 7'd60;
         hour_up = hour_up + 6'd1;
         if (hour_up >= 6'd24) hour_up = hour_up - 6'd24;
      end
      seg_round.milli  = 10'd0;
      seg_round.second = 6'd0;
      seg_round.minute = min_up[5:0];
      seg_round.hour   = hour_up[4:0];
   end

   // next state per operation
   always_comb begin
      run_in  = run_ff;
      ref_in  = ref_ff;
      base_in = base_ff;
      cur_in  = cur_ff;
      if (take) begin
         case (item.op)
            OP_TICK: begin
               if (run_ff) cur_in = running;
            end
            OP_TOGGLE: begin
               run_in = !run_ff;
               if (!run_ff) begin
                  ref_in  = item.now;
                  base_in = cur_ff;
               end else begin
                  base_in = round_up_enable ? seg_round : seg_raw;
               end
            end
            OP_RESET: begin
               ref_in  = item.now;
               base_in = '0;
               cur_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // result handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         ref_ff       <= '0;
         base_ff      <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         ref_ff       <= ref_in;
         base_ff      <= base_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign run_time   = cur_ff;
   assign seg_time   = base_ff;
   assign is_running = run_ff;

endmodule

[rtl/core/hms_ms_stopwatch_unit.sv]
// top level of the hour:minute:second:millisecond stopwatch
//
// Each request transfer carries an operation (tick, start/stop toggle or
// reset) and the current time of day; each one yields exactly one response
// transfer with the running value, the base or last stopped segment and the
// run flag, all taken after the update. Time fields above their digit
// maximum are clamped before use.
// Each request is held in the input register before the state update,
// whose registers also hold the response. Throughput is one item per cycle
// while the receiver takes responses; the limit is the single state update
// per cycle through the borrow and carry chains of the core. When the
// receiver stalls, the response holds and one more item waits in the input
// register; request ready then drops until the response is taken. Reset
// clears the run flag, the start time, base and running values, the
// round-up register and both pipeline valids. The user must write the
// round-up register through the apb-style port only while the block idles;
// this is not checked. Writes ignore paddr; reads use byte address 0.
`timescale 1ns / 1ps

module hms_ms_stopwatch_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [4:0]  req_now_hour,
   input  logic [5:0]  req_now_minute,
   input  logic [5:0]  req_now_second,
   input  logic [9:0]  req_now_milli,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_run_hour,
   output logic [5:0]  rsp_run_minute,
   output logic [5:0]  rsp_run_second,
   output logic [9:0]  rsp_run_milli,
   output logic [4:0]  rsp_seg_hour,
   output logic [5:0]  rsp_seg_minute,
   output logic [5:0]  rsp_seg_second,
   output logic [9:0]  rsp_seg_milli,
   output logic        rsp_is_running,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import hmssw_pkg::*;

   logic     round_up_enable;
   logic     item_valid;
   item_type item;
   logic     take;
   time_type run_time;
   time_type seg_time;

   // configuration registers
   hmssw_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .round_up_enable (round_up_enable)
   );

   // input register
   hmssw_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_now_hour   (req_now_hour),
      .req_now_minute (req_now_minute),
      .req_now_second (req_now_second),
      .req_now_milli  (req_now_milli),
      .take           (take),
      .item_valid     (item_valid),
      .item           (item)
   );

   // state update and result
   hmssw_core u_core (
      .clock           (clock),
      .reset           (reset),
      .round_up_enable (round_up_enable),
      .item_valid      (item_valid),
      .item            (item),
      .take            (take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .run_time        (run_time),
      .seg_time        (seg_time),
      .is_running      (rsp_is_running)
   );

   assign rsp_run_hour   = run_time.hour;
   assign rsp_run_minute = run_time.minute;
   assign rsp_run_second = run_time.second;
   assign rsp_run_milli  = run_time.milli;
   assign rsp_seg_hour   = seg_time.hour;
   assign rsp_seg_minute = seg_time.minute;
   assign rsp_seg_second = seg_time.second;
   assign rsp_seg_milli  = seg_time.milli;

endmodule
